// File: design/scan_rate_pwm_stepper_core_macros.svh
// Assertion macros for the scan rate PWM stepper core.
// Self-contained; included by the files that carry concurrent assertions.
// Define ASSERT_OFF to compile every assertion away.
`ifndef SCAN_RATE_PWM_STEPPER_CORE_MACROS_SVH
`define SCAN_RATE_PWM_STEPPER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// The condition must never be seen at a clock edge outside reset.
`define SRPS_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed: forbidden condition seen");
// Whenever the trigger holds, the consequence holds in the same cycle.
`define SRPS_ASSERT_IMPLY(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error("assertion failed: same-cycle implication broken");
// Whenever the trigger holds, the consequence holds in the next cycle.
`define SRPS_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("assertion failed: next-cycle implication broken");
`else
`define SRPS_ASSERT_NEVER(label, clk, rst_n, cond)
`define SRPS_ASSERT_IMPLY(label, clk, rst_n, trig, cons)
`define SRPS_ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif
`endif

// File: design/srps_pkg.sv
// Shared types and constants of the scan rate PWM stepper core.
// No dependencies; imported by every module of the block.
`default_nettype none

package srps_pkg;

	localparam int SUM_W      = 40;
	localparam int FREQ_W     = 24;
	localparam int CNT_W      = 8;
	localparam int MHZ_W      = 17;
	localparam int CPWM_W     = 10;
	localparam int ACT_W      = 2;
	localparam int K_W        = 30;
	localparam int NUM_W      = CNT_W + K_W;
	localparam int DIV_CNT_W  = $clog2(NUM_W);
	localparam int OUT_DATA_W = 40;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [SUM_W-1:0]  SUM_MAX        = {SUM_W{1'b1}};
	localparam logic [FREQ_W-1:0] FREQ_MAX       = {FREQ_W{1'b1}};
	localparam logic [K_W-1:0]    MHZ_PER_INV_US = 30'd1000000000;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [MHZ_W-1:0]  RST_TARGET   = 17'd10000;
	localparam logic [MHZ_W-1:0]  RST_HYST     = 17'd500;
	localparam logic [CPWM_W-1:0] RST_STEP     = 10'd30;
	localparam logic [CNT_W-1:0]  RST_WINDOW   = 8'd40;
	localparam logic [CPWM_W-1:0] RST_PWM_MIN  = 10'd0;
	localparam logic [CPWM_W-1:0] RST_PWM_MAX  = 10'd1023;
	localparam logic [CPWM_W-1:0] RST_INIT_PWM = 10'd650;

	typedef enum logic [ACT_W-1:0] {
		ACT_HOLD    = 2'd0,
		ACT_UP      = 2'd1,
		ACT_DOWN    = 2'd2,
		ACT_REFUSED = 2'd3
	} action_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TARGET   = 3'd0,
		REG_HYST     = 3'd1,
		REG_STEP     = 3'd2,
		REG_WINDOW   = 3'd3,
		REG_PWM_MIN  = 3'd4,
		REG_PWM_MAX  = 3'd5,
		REG_INIT_PWM = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_DONE
	} back_state_t;

	// One finished measurement window handed from front to back.
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
	} win_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic busy;
		logic commit;
	} back_stat_t;

	// Settings used by the back part.
	typedef struct packed {
		logic [MHZ_W-1:0]  target;
		logic [MHZ_W-1:0]  hyst;
		logic [CPWM_W-1:0] step;
		logic [CPWM_W-1:0] pwm_min;
		logic [CPWM_W-1:0] pwm_max;
	} cfg_t;

endpackage

`default_nettype wire

// File: design/srps_front.sv
// Front part: accepts timestamps, accumulates intervals and closes windows.
// Depends on srps_pkg; pushes each finished window into srps_fifo.
`default_nettype none

module srps_front #(
	parameter int STAMP_WIDTH = 32,
	parameter int MAX_WINDOW  = 255
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [srps_pkg::CNT_W-1:0] window_count,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [STAMP_WIDTH-1:0]     stamp,
	input  wire srps_pkg::fifo_stat_t       qstat,
	output logic                            push,
	output srps_pkg::win_t                  win
);
	import srps_pkg::*;

	localparam int ACC_W = ((STAMP_WIDTH > SUM_W) ? STAMP_WIDTH : SUM_W) + 1;
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam logic [CNT_W-1:0] WIN_CLIP =
		CNT_W'((MAX_WINDOW > CNT_MAX) ? CNT_MAX : MAX_WINDOW);

	logic [STAMP_WIDTH-1:0] prev_q;
	logic                   have_prev_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SUM_W-1:0]       sum_q;

	logic                   accept;
	logic [CNT_W-1:0]       eff_count;
	logic [STAMP_WIDTH-1:0] interval;
	logic [ACC_W-1:0]       acc;
	logic [SUM_W-1:0]       sum_new;
	logic [CNT_W-1:0]       cnt_new;
	logic                   done;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		eff_count = (window_count == '0) ? CNT_W'(1) : window_count;
		if (eff_count > WIN_CLIP) begin
			eff_count = WIN_CLIP;
		end
	end

	// Interval wraps with the timestamp; the window sum saturates.
	assign interval = stamp - prev_q;
	assign acc      = ACC_W'(sum_q) + ACC_W'(interval);
	assign sum_new  = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
	assign cnt_new  = cnt_q + CNT_W'(1);
	assign done     = (cnt_new >= eff_count);

	assign push      = accept && have_prev_q && done;
	assign win.count = eff_count;
	assign win.sum   = sum_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			cnt_q       <= '0;
			sum_q       <= '0;
		end else if (accept) begin
			prev_q      <= stamp;
			have_prev_q <= 1'b1;
			if (have_prev_q) begin
				if (done) begin
					cnt_q <= '0;
					sum_q <= '0;
				end else begin
					cnt_q <= cnt_new;
					sum_q <= sum_new;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: design/srps_fifo.sv
// Two-entry queue of finished windows between the front and back parts.
// Depends on srps_pkg for the entry type and the depth.
`default_nettype none

module srps_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire srps_pkg::win_t       wdata,
	input  wire logic                 pop,
	output srps_pkg::win_t            rdata,
	output srps_pkg::fifo_stat_t      stat
);
	import srps_pkg::*;

	win_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rd_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_inc(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: design/srps_back.sv
// Back part: frequency estimate by bit-serial division, PWM stepping, result register.
// Depends on srps_pkg; takes windows from srps_fifo.
`default_nettype none

module srps_back #(
	parameter int PWM_WIDTH = 10
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire srps_pkg::cfg_t                  cfg,
	input  wire srps_pkg::win_t                  win,
	input  wire logic                            win_avail,
	output logic                                 win_pop,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [srps_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output srps_pkg::back_stat_t                 stat
);
	import srps_pkg::*;

	localparam int PX = ((PWM_WIDTH > CPWM_W) ? PWM_WIDTH : CPWM_W) + 1;
	localparam logic [PX-1:0] PWM_MASK = PX'((1 << PWM_WIDTH) - 1);
	localparam logic [PWM_WIDTH-1:0] PWM_RESET = PWM_WIDTH'(RST_INIT_PWM);

	back_state_t state_q, state_d;

	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     den_q;
	logic [NUM_W-1:0]     quo_q;
	logic [SUM_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [PWM_WIDTH-1:0] pwm_q;
	logic                 out_valid_q;
	logic [CPWM_W-1:0]    out_pwm_q;
	logic [FREQ_W-1:0]    out_freq_q;
	action_t              out_act_q;

	logic mul_en, div_en, commit, slot_free, div_last;

	logic [SUM_W:0]       shifted;
	logic                 ge;
	logic [SUM_W:0]       diff;

	logic [FREQ_W-1:0]    freq;
	logic                 go_up, go_down;
	logic [PX-1:0]        pwm_e, step_e, min_e, max_e, up_next, dn_next, new_e;
	action_t              act;

	assign slot_free = !out_valid_q || m_axis_tready;
	assign div_last  = (step_q == DIV_CNT_W'(NUM_W - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (win_avail) state_d = BK_MUL;
			BK_MUL:  state_d = BK_DIV;
			BK_DIV:  if (div_last) state_d = BK_DONE;
			BK_DONE: if (slot_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		win_pop = (state_q == BK_IDLE) && win_avail;
		mul_en  = (state_q == BK_MUL);
		div_en  = (state_q == BK_DIV);
		commit  = (state_q == BK_DONE) && slot_free;
	end

	// One restoring division step per cycle, quotient bits shift in at the bottom.
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign ge      = (shifted >= {1'b0, den_q});
	assign diff    = shifted - {1'b0, den_q};

	always_comb begin
		if (den_q == '0 || quo_q > NUM_W'(FREQ_MAX)) begin
			freq = FREQ_MAX;
		end else begin
			freq = quo_q[FREQ_W-1:0];
		end
		go_up   = ((FREQ_W+1)'(freq) + (FREQ_W+1)'(cfg.hyst)) < (FREQ_W+1)'(cfg.target);
		go_down = (FREQ_W+1)'(freq) > ((FREQ_W+1)'(cfg.target) + (FREQ_W+1)'(cfg.hyst));

		pwm_e   = PX'(pwm_q);
		step_e  = PX'(cfg.step);
		min_e   = PX'(cfg.pwm_min);
		max_e   = PX'(cfg.pwm_max);
		up_next = pwm_e + step_e;
		dn_next = pwm_e - step_e;
		new_e   = pwm_e;
		act     = ACT_HOLD;
		priority if (go_up) begin
			if (up_next > max_e || up_next < min_e || up_next > PWM_MASK) begin
				act = ACT_REFUSED;
			end else begin
				new_e = up_next;
				act   = ACT_UP;
			end
		end else if (go_down) begin
			if (pwm_e < step_e || dn_next < min_e || dn_next > max_e) begin
				act = ACT_REFUSED;
			end else begin
				new_e = dn_next;
				act   = ACT_DOWN;
			end
		end else begin
			act = ACT_HOLD;
		end
	end

	always_ff @(posedge clk) begin
		if (win_pop) begin
			cnt_q <= win.count;
			den_q <= win.sum;
		end
		if (mul_en) begin
			quo_q <= NUM_W'(cnt_q) * NUM_W'(MHZ_PER_INV_US);
			rem_q <= '0;
		end else if (div_en) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
		end
		if (commit) begin
			out_pwm_q  <= new_e[CPWM_W-1:0];
			out_freq_q <= freq;
			out_act_q  <= act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			step_q      <= '0;
			pwm_q       <= PWM_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_en) begin
				step_q <= '0;
			end else if (div_en) begin
				step_q <= step_q + DIV_CNT_W'(1);
			end
			if (commit) begin
				pwm_q       <= new_e[PWM_WIDTH-1:0];
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		(OUT_DATA_W - CPWM_W - FREQ_W - ACT_W)'(0), out_act_q, out_freq_q, out_pwm_q
	};

	assign stat.busy   = (state_q != BK_IDLE);
	assign stat.commit = commit;

endmodule

`default_nettype wire

// File: design/scan_rate_pwm_stepper_core.sv
// Scan rate PWM stepper: timestamps in, one bang-bang PWM correction per
// measurement window out. A stamp is taken whenever the window queue has room.
// A completed window is taken from the queue, multiplied, divided bit-serially
// and loaded into the result register once the output register is free. The back
// part handles one window at a time and takes no new window until it has finished
// the last one. Up to two completed windows wait in the queue while the divider
// is busy, and stamps that do not close a window keep flowing at one per cycle
// while the queue is not full. The first stamp after reset only sets the reference
// time. Each result carries the running PWM after the decision, the window
// frequency in millihertz (saturating at all ones, also for a zero interval sum)
// and the action taken: hold, step up, step down, or a step refused because it
// would leave the allowed PWM range. Settings are to be written over the APB port
// only while the block is idle; the block itself does not enforce this.
// initial_pwm is stored and read back but does not set the PWM at reset.
// Depends on srps_pkg, srps_front, srps_fifo, srps_back and the assertion macros.
`default_nettype none
`include "scan_rate_pwm_stepper_core_macros.svh"

module scan_rate_pwm_stepper_core #(
	parameter int STAMP_WIDTH = 32,
	parameter int PWM_WIDTH   = 10,
	parameter int MAX_WINDOW  = 255
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// APB configuration port
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [srps_pkg::APB_ADDR_W-1:0]        paddr,
	input  wire logic [srps_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [srps_pkg::APB_DATA_W-1:0]             prdata,
	output logic                                        pready,
	// Timestamp requests
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	// tdata: stamp, then zero padding to whole bytes
	input  wire logic [((STAMP_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// Result requests
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// tdata: pwm_value [9:0], measured_frequency [33:10], action [35:34], zero [39:36]
	output logic [srps_pkg::OUT_DATA_W-1:0]             m_axis_tdata
);
	import srps_pkg::*;

	// Settings registers.
	logic [MHZ_W-1:0]  target_q;
	logic [MHZ_W-1:0]  hyst_q;
	logic [CPWM_W-1:0] step_q;
	logic [CNT_W-1:0]  window_q;
	logic [CPWM_W-1:0] pwm_min_q;
	logic [CPWM_W-1:0] pwm_max_q;
	logic [CPWM_W-1:0] init_pwm_q;

	logic       wr_en;
	reg_idx_t   reg_idx;
	cfg_t       cfg;

	win_t       push_win, pop_win;
	logic       push, pop;
	fifo_stat_t qstat;
	back_stat_t bstat;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= RST_TARGET;
			hyst_q     <= RST_HYST;
			step_q     <= RST_STEP;
			window_q   <= RST_WINDOW;
			pwm_min_q  <= RST_PWM_MIN;
			pwm_max_q  <= RST_PWM_MAX;
			init_pwm_q <= RST_INIT_PWM;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TARGET:   target_q   <= pwdata[MHZ_W-1:0];
				REG_HYST:     hyst_q     <= pwdata[MHZ_W-1:0];
				REG_STEP:     step_q     <= pwdata[CPWM_W-1:0];
				REG_WINDOW:   window_q   <= pwdata[CNT_W-1:0];
				REG_PWM_MIN:  pwm_min_q  <= pwdata[CPWM_W-1:0];
				REG_PWM_MAX:  pwm_max_q  <= pwdata[CPWM_W-1:0];
				REG_INIT_PWM: init_pwm_q <= pwdata[CPWM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Reads return the stored value; addresses past the last register read zero.
	always_comb begin
		unique case (reg_idx)
			REG_TARGET:   prdata = APB_DATA_W'(target_q);
			REG_HYST:     prdata = APB_DATA_W'(hyst_q);
			REG_STEP:     prdata = APB_DATA_W'(step_q);
			REG_WINDOW:   prdata = APB_DATA_W'(window_q);
			REG_PWM_MIN:  prdata = APB_DATA_W'(pwm_min_q);
			REG_PWM_MAX:  prdata = APB_DATA_W'(pwm_max_q);
			REG_INIT_PWM: prdata = APB_DATA_W'(init_pwm_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.target  = target_q;
	assign cfg.hyst    = hyst_q;
	assign cfg.step    = step_q;
	assign cfg.pwm_min = pwm_min_q;
	assign cfg.pwm_max = pwm_max_q;

	// Front part: interval accumulation and window closing.
	srps_front #(
		.STAMP_WIDTH (STAMP_WIDTH),
		.MAX_WINDOW  (MAX_WINDOW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.window_count (window_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.stamp        (s_axis_tdata[STAMP_WIDTH-1:0]),
		.qstat        (qstat),
		.push         (push),
		.win          (push_win)
	);

	// Queue of completed windows; decouples stamp intake from the divider.
	srps_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_win),
		.pop    (pop),
		.rdata  (pop_win),
		.stat   (qstat)
	);

	// Back part: estimate, decision and result register.
	srps_back #(
		.PWM_WIDTH (PWM_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.win           (pop_win),
		.win_avail     (!qstat.empty),
		.win_pop       (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.stat          (bstat)
	);

	// A completed window must never be pushed into a full queue.
	`SRPS_ASSERT_NEVER(a_queue_no_overflow, clk, arst_n, push && qstat.full)
	// The back part takes a new window only when it has finished the last one.
	`SRPS_ASSERT_IMPLY(a_pop_when_idle, clk, arst_n, pop, !bstat.busy && !qstat.empty)
	// A result is loaded only into a free or draining output register.
	`SRPS_ASSERT_IMPLY(a_commit_slot_free, clk, arst_n, bstat.commit, !m_axis_tvalid || m_axis_tready)
	// A loaded result is offered in the following cycle.
	`SRPS_ASSERT_NEXT(a_commit_offered, clk, arst_n, bstat.commit, m_axis_tvalid)

endmodule

`default_nettype wire

// File: bench/scan_rate_pwm_stepper_core_tb.sv
// Self-checking bench for the scan rate PWM stepper core: timestamp requests in, one
// PWM correction request per measurement window out, checked against a predictor.
// Depends on srps_pkg and scan_rate_pwm_stepper_core.
`timescale 1ns / 1ps

module scan_rate_pwm_stepper_core_tb;
	import srps_pkg::*;

	localparam logic [39:0] TOTAL_CAP = '1;
	localparam logic [23:0] FREQ_CAP  = '1;
	localparam int          PWM_TOP   = 1023;
	localparam int          REST_CYCLES = 64;

	typedef struct {
		logic [9:0]  pwm;
		logic [23:0] freq;
		action_t     act;
	} pwm_correction_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [39:0] m_axis_tdata;

	// Settings as the block should hold them.
	logic [16:0] target_mhz = 17'd10000;
	logic [16:0] dead_band = 17'd500;
	logic [9:0]  step_size = 10'd30;
	logic [7:0]  window_len = 8'd40;
	logic [9:0]  pwm_floor = 10'd0;
	logic [9:0]  pwm_ceil = 10'd1023;
	logic [9:0]  pwm_at_reset = 10'd650;

	// Regulator state as the block should hold it.
	logic [31:0] last_stamp = '0;
	logic        have_last = 1'b0;
	logic [7:0]  intervals_seen = '0;
	logic [39:0] interval_total = '0;
	logic [9:0]  pwm_now = 10'd650;

	logic [31:0]     stamp_backlog[$];
	pwm_correction_t awaited_corrections[$];
	logic [31:0]     stamp_clock = '0;
	int              mismatch_count = 0;
	int              source_gap = 0;
	int              sink_gap = 0;
	logic            idle_on = 1'b1;
	logic            long_hold_req = 1'b0;
	logic            sink_blocked = 1'b0;

	scan_rate_pwm_stepper_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		// tdata: stamp [31:0]
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		// tdata: pwm_value [9:0], measured_frequency [33:10], action [35:34], zero [39:36]
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_fault(input string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Folds one accepted timestamp into the window and, when the window closes,
	// works out the frequency, the bang-bang decision and the PWM that follows.
	task automatic regulate_on_stamp(input logic [31:0] stamp);
		logic [31:0]     gap_us;
		logic [63:0]     total;
		logic [63:0]     count;
		logic [63:0]     freq;
		logic [63:0]     next_pwm;
		pwm_correction_t outcome;
		if (!have_last) begin
			have_last  = 1'b1;
			last_stamp = stamp;
			return;
		end
		gap_us = stamp - last_stamp;
		total = interval_total + gap_us;
		interval_total = (total > TOTAL_CAP) ? TOTAL_CAP : total[39:0];
		last_stamp = stamp;
		intervals_seen = intervals_seen + 8'd1;
		// A window length of zero counts as one interval.
		count = (window_len == 0) ? 64'd1 : 64'(window_len);
		if (intervals_seen < count)
			return;
		if (interval_total == 0) begin
			freq = FREQ_CAP;
		end else begin
			freq = (count * 64'd1000000000) / interval_total;
			if (freq > FREQ_CAP)
				freq = FREQ_CAP;
		end
		outcome.act = ACT_HOLD;
		if (freq + dead_band < target_mhz) begin
			next_pwm = pwm_now + step_size;
			if (next_pwm > pwm_ceil || next_pwm < pwm_floor || next_pwm > PWM_TOP) begin
				outcome.act = ACT_REFUSED;
			end else begin
				pwm_now = next_pwm[9:0];
				outcome.act = ACT_UP;
			end
		end else if (freq > target_mhz + dead_band) begin
			if (pwm_now < step_size) begin
				outcome.act = ACT_REFUSED;
			end else begin
				next_pwm = pwm_now - step_size;
				if (next_pwm < pwm_floor || next_pwm > pwm_ceil) begin
					outcome.act = ACT_REFUSED;
				end else begin
					pwm_now = next_pwm[9:0];
					outcome.act = ACT_DOWN;
				end
			end
		end
		intervals_seen = '0;
		interval_total = '0;
		outcome.pwm  = pwm_now;
		outcome.freq = freq[23:0];
		awaited_corrections.insert(awaited_corrections.size(), outcome);
	endtask

	// Timestamp driver: offers requests from the backlog and predicts on each
	// accepted one. A random gap may follow each request while idling is on.
	always @(posedge clk) begin : stamp_driver
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				regulate_on_stamp(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (source_gap > 0 || stamp_backlog.size() == 0) begin
					if (source_gap > 0)
						source_gap--;
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tdata  <= stamp_backlog.pop_front();
					s_axis_tvalid <= 1'b1;
					if (idle_on && $urandom_range(0, 4) == 0)
						source_gap = $urandom_range(1, 5);
				end
			end
		end
	end

	// Result monitor: checks every accepted correction against the oldest one
	// awaited and stalls the output at random.
	always @(posedge clk) begin : correction_monitor
		pwm_correction_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_corrections.size() == 0) begin
					report_fault($sformatf("unexpected result %h", m_axis_tdata));
				end else begin
					want = awaited_corrections.pop_front();
					if (m_axis_tdata[9:0] != want.pwm)
						report_fault($sformatf("pwm_value %0d, wanted %0d",
							m_axis_tdata[9:0], want.pwm));
					if (m_axis_tdata[33:10] != want.freq)
						report_fault($sformatf("measured_frequency %0d, wanted %0d",
							m_axis_tdata[33:10], want.freq));
					if (action_t'(m_axis_tdata[35:34]) != want.act)
						report_fault($sformatf("action %0d, wanted %s",
							m_axis_tdata[35:34], want.act.name()));
					if (m_axis_tdata[39:36] != 4'd0)
						report_fault($sformatf("padding bits %h not zero",
							m_axis_tdata[39:36]));
				end
			end
			if (sink_blocked) begin
				m_axis_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 5) == 0)
					sink_gap = $urandom_range(1, 5);
			end
		end
	end

	// Long hold-off of the receiver, so that the queue fills and the input stalls.
	initial begin : sink_hold_off
		int held;
		while (!long_hold_req)
			@(posedge clk);
		sink_blocked <= 1'b1;
		for (held = 0; held < 600; held++)
			@(posedge clk);
		sink_blocked <= 1'b0;
	end

	initial begin : watchdog
		#5_000_000;
		$display("scan_rate_pwm_stepper_core_tb: FAIL");
		$finish;
	end

	task automatic write_setting(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_TARGET:   target_mhz = value[16:0];
			REG_HYST:     dead_band = value[16:0];
			REG_STEP:     step_size = value[9:0];
			REG_WINDOW:   window_len = value[7:0];
			REG_PWM_MIN:  pwm_floor = value[9:0];
			REG_PWM_MAX:  pwm_ceil = value[9:0];
			REG_INIT_PWM: pwm_at_reset = value[9:0];
			default: ;
		endcase
	endtask

	// Waits until every request has gone in and every correction has come out,
	// then lets the block finish any window still on its way through.
	task automatic drain_and_rest();
		do
			@(posedge clk);
		while (stamp_backlog.size() != 0 || s_axis_tvalid || awaited_corrections.size() != 0);
		repeat (REST_CYCLES) @(posedge clk);
	endtask

	task automatic queue_after(input logic [31:0] gap_us);
		stamp_clock = stamp_clock + gap_us;
		stamp_backlog.insert(stamp_backlog.size(), stamp_clock);
	endtask

	// Mostly windows whose intervals sit near the target rate, so that hold, up
	// and down all come up, with the odd wild or tiny interval mixed in.
	task automatic queue_random_windows(input int items);
		int          n;
		int          span;
		int          rate;
		logic [31:0] period;
		logic [31:0] gap_us;
		span = (window_len == 0) ? 1 : window_len;
		period = 32'd100000;
		for (n = 0; n < items; n++) begin
			if (n % span == 0) begin
				rate = (target_mhz * $urandom_range(60, 140)) / 100;
				if (rate < 1000)
					rate = 1000;
				period = 1000000000 / rate;
			end
			case ($urandom_range(0, 11))
				0: gap_us = $urandom();
				1: gap_us = $urandom_range(0, 100);
				default: gap_us = period - period / 4 + $urandom_range(0, period / 2);
			endcase
			queue_after(gap_us);
		end
	endtask

	task automatic shuffle_settings();
		case ($urandom_range(0, 5))
			0: write_setting(REG_TARGET, 0);
			1: write_setting(REG_TARGET, 100000);
			default: write_setting(REG_TARGET, $urandom_range(1000, 100000));
		endcase
		case ($urandom_range(0, 5))
			0: write_setting(REG_HYST, 0);
			1: write_setting(REG_HYST, 100000);
			default: write_setting(REG_HYST, $urandom_range(0, 3000));
		endcase
		case ($urandom_range(0, 5))
			0: write_setting(REG_STEP, 0);
			1: write_setting(REG_STEP, 1023);
			default: write_setting(REG_STEP, $urandom_range(1, 120));
		endcase
		if ($urandom_range(0, 5) == 0)
			write_setting(REG_WINDOW, 0);
		else
			write_setting(REG_WINDOW, $urandom_range(1, 6));
		case ($urandom_range(0, 5))
			0: begin
				write_setting(REG_PWM_MIN, 0);
				write_setting(REG_PWM_MAX, 1023);
			end
			1: begin
				// Floor above ceiling: every step must be refused.
				write_setting(REG_PWM_MIN, $urandom_range(512, 1023));
				write_setting(REG_PWM_MAX, $urandom_range(0, 511));
			end
			default: begin
				write_setting(REG_PWM_MIN, $urandom_range(0, 300));
				write_setting(REG_PWM_MAX, $urandom_range(700, 1023));
			end
		endcase
		write_setting(REG_INIT_PWM, $urandom_range(0, 1023));
	endtask

	initial begin : stimulus
		int p;
		int k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// The very first stamp is zero and only sets the reference time; the
		// five intervals after it leave the 40-interval window part filled.
		stamp_backlog.insert(stamp_backlog.size(), 32'd0);
		for (k = 0; k < 5; k++)
			queue_after(32'd100000);
		drain_and_rest();

		// Shortening the window mid-way closes it on the very next interval.
		write_setting(REG_WINDOW, 2);
		queue_after(32'd100000);
		drain_and_rest();

		// A window length of zero acts as one. A zero sum and a huge quotient
		// both saturate the frequency; a wrapped interval gives a frequency of
		// zero. Large steps are refused in both directions.
		write_setting(REG_WINDOW, 0);
		write_setting(REG_TARGET, 100000);
		write_setting(REG_HYST, 0);
		write_setting(REG_STEP, 1023);
		write_setting(REG_INIT_PWM, 1023);
		queue_after(32'd0);
		queue_after(32'd1);
		queue_after(32'hFFFF_FFFF);
		queue_after(32'h8000_0000);
		drain_and_rest();

		// Step up exactly onto the top of the range, then past it.
		write_setting(REG_STEP, 343);
		queue_after(32'd1000000);
		queue_after(32'd1000000);
		drain_and_rest();

		// Step down exactly onto zero, then below it.
		write_setting(REG_TARGET, 0);
		write_setting(REG_STEP, 1023);
		queue_after(32'd10000);
		queue_after(32'd10000);
		drain_and_rest();

		// Inside a wide dead band nothing moves; with the floor above the
		// ceiling every step is refused.
		write_setting(REG_TARGET, 10000);
		write_setting(REG_HYST, 100000);
		write_setting(REG_STEP, 5);
		write_setting(REG_PWM_MIN, 600);
		write_setting(REG_PWM_MAX, 500);
		queue_after(32'd100000);
		drain_and_rest();
		write_setting(REG_HYST, 0);
		queue_after(32'd100000);
		queue_after(32'd200000);
		queue_after(32'd50000);
		drain_and_rest();

		// One window of the longest length, built from intervals near the wrap,
		// which drives the sum close to its ceiling.
		write_setting(REG_TARGET, 10000);
		write_setting(REG_HYST, 500);
		write_setting(REG_STEP, 30);
		write_setting(REG_PWM_MIN, 0);
		write_setting(REG_PWM_MAX, 1023);
		write_setting(REG_WINDOW, 255);
		for (k = 0; k < 255; k++)
			queue_after($urandom_range(32'hF000_0000, 32'hFFFF_FFFF));
		drain_and_rest();

		// Random phases, each under fresh settings. In one of them the receiver
		// holds off for a long time while every stamp closes a window, and
		// the final phases run with no idling on either side.
		for (p = 0; p < 12; p++) begin
			drain_and_rest();
			shuffle_settings();
			idle_on <= (p < 9) && ($urandom_range(0, 3) != 0);
			if (p == 4) begin
				write_setting(REG_WINDOW, 1);
				long_hold_req <= 1'b1;
				queue_random_windows(40);
			end else begin
				queue_random_windows(30);
			end
		end

		drain_and_rest();
		if (mismatch_count == 0 && awaited_corrections.size() == 0)
			$display("scan_rate_pwm_stepper_core_tb: PASS");
		else
			$display("scan_rate_pwm_stepper_core_tb: FAIL");
		$finish;
	end

endmodule
